@@ hdl/sts_pkg.sv @@
`default_nettype none
package sts_pkg;

   localparam int COMP_W     = 16;
   localparam int SUM_W      = COMP_W + 1;
   localparam int SQ_W       = 2 * SUM_W - 1;
   localparam int SUMSQ_W    = SQ_W + 1;
   localparam int REM_W      = SUMSQ_W + 1;
   localparam int QUO_W      = 31;
   localparam int RES_W      = QUO_W + 1;
   localparam int Q_W        = 15;
   localparam int DIV_STEPS  = QUO_W;
   localparam int SQRT_STEPS = (QUO_W + 1) / 2;
   localparam int LANE_LAT   = 1 + DIV_STEPS + SQRT_STEPS + 1;

   localparam int MAX_LEVELS = 2;
   localparam int VTX_N      = 18;
   localparam int VIDX_W     = 5;
   localparam int MID_N      = 15;
   localparam int MIDX_W     = 4;
   localparam int EMIT_W     = 6;

   localparam int FIFO_DEPTH = 64;
   localparam int FIFO_AW    = 6;

   localparam logic REG_SUBDIV = 1'b0;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [SUM_W-1:0]  scomp_type;

   typedef struct packed {
      comp_type z;
      comp_type y;
      comp_type x;
   } vec_type;

   typedef struct packed {
      scomp_type z;
      scomp_type y;
      scomp_type x;
   } svec_type;

   typedef struct packed {
      vec_type c;
      vec_type b;
      vec_type a;
   } tri_type;

   typedef struct packed {
      logic              emit;
      logic              last;
      logic [VIDX_W-1:0] dest;
      vec_type           pos;
   } tag_type;

   typedef struct packed {
      logic    last;
      vec_type nrm;
      vec_type pos;
   } word_type;

   localparam logic [VIDX_W-1:0] EMIT_L0 [3] = '{5'd0, 5'd1, 5'd2};

   localparam logic [VIDX_W-1:0] EMIT_L1 [12] = '{
      5'd0, 5'd3, 5'd5,  5'd1, 5'd4, 5'd3,  5'd2, 5'd5, 5'd4,  5'd3, 5'd4, 5'd5};

   localparam logic [VIDX_W-1:0] EMIT_L2 [48] = '{
      5'd0,  5'd6,  5'd8,   5'd3,  5'd7,  5'd6,   5'd5,  5'd8,  5'd7,
      5'd6,  5'd7,  5'd8,   5'd1,  5'd9,  5'd11,  5'd4,  5'd10, 5'd9,
      5'd3,  5'd11, 5'd10,  5'd9,  5'd10, 5'd11,  5'd2,  5'd12, 5'd14,
      5'd5,  5'd13, 5'd12,  5'd4,  5'd14, 5'd13,  5'd12, 5'd13, 5'd14,
      5'd3,  5'd15, 5'd17,  5'd4,  5'd16, 5'd15,  5'd5,  5'd17, 5'd16,
      5'd15, 5'd16, 5'd17};

   localparam logic [VIDX_W-1:0] MID_SRC_A [MID_N] = '{
      5'd0, 5'd1, 5'd2,  5'd0, 5'd3, 5'd5,  5'd1, 5'd4, 5'd3,
      5'd2, 5'd5, 5'd4,  5'd3, 5'd4, 5'd5};

   localparam logic [VIDX_W-1:0] MID_SRC_B [MID_N] = '{
      5'd1, 5'd2, 5'd0,  5'd3, 5'd5, 5'd0,  5'd4, 5'd3, 5'd1,
      5'd5, 5'd4, 5'd2,  5'd4, 5'd5, 5'd3};

   function automatic logic [VIDX_W-1:0] emit_vidx(input logic [1:0] lvl,
                                                  input logic [EMIT_W-1:0] n);
      logic [VIDX_W-1:0] v;
      case (lvl)
         2'd0:    v = EMIT_L0[n[1:0]];
         2'd1:    v = EMIT_L1[n[3:0]];
         default: v = EMIT_L2[n];
      endcase
      return v;
   endfunction

   function automatic logic [EMIT_W-1:0] emit_total(input logic [1:0] lvl);
      logic [EMIT_W-1:0] t;
      case (lvl)
         2'd0:    t = EMIT_W'(3);
         2'd1:    t = EMIT_W'(12);
         default: t = EMIT_W'(48);
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

@@ hdl/sts_lane.sv @@
`default_nettype none
module sts_lane (
   input  wire logic                        clock,
   input  wire logic [sts_pkg::SQ_W-1:0]    in_sq,
   input  wire logic [sts_pkg::SUMSQ_W-1:0] in_ss,
   output logic      [sts_pkg::Q_W-1:0]     out_q
);

   localparam int REM_W = sts_pkg::REM_W;
   localparam int QUO_W = sts_pkg::QUO_W;
   localparam int RES_W = sts_pkg::RES_W;
   localparam int DS    = sts_pkg::DIV_STEPS;
   localparam int SS    = sts_pkg::SQRT_STEPS;

   logic [REM_W-1:0] rem_ff [DS+1];
   logic [REM_W-1:0] den_ff [DS+1];
   logic [QUO_W-1:0] quo_ff [DS+1];
   logic [QUO_W-1:0] op_ff  [SS];
   logic [RES_W-1:0] res_ff [SS];
   logic [sts_pkg::Q_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      rem_ff[0] <= REM_W'(in_sq);
      den_ff[0] <= REM_W'(in_ss);
      quo_ff[0] <= '0;
   end

   // restoring divide: quotient = sq * 2^30 / ss
   for (genvar j = 0; j < DS; j++) begin : g_div
      logic             ge;
      logic [REM_W-1:0] sub;
      logic [REM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;
      always_comb begin
         ge     = rem_ff[j] >= den_ff[j];
         sub    = ge ? rem_ff[j] - den_ff[j] : rem_ff[j];
         rem_in = {sub[REM_W-2:0], 1'b0};
         quo_in = {quo_ff[j][QUO_W-2:0], ge};
      end
      always_ff @(posedge clock) begin
         rem_ff[j+1] <= rem_in;
         den_ff[j+1] <= den_ff[j];
         quo_ff[j+1] <= quo_in;
      end
   end

   // digit-by-digit integer square root of the quotient
   for (genvar k = 0; k < SS; k++) begin : g_sqrt
      localparam logic [RES_W-1:0] ONE_K = RES_W'(1) << (QUO_W - 1 - 2 * k);
      logic [QUO_W-1:0] op_cur;
      logic [RES_W-1:0] res_cur;
      logic [RES_W-1:0] trial;
      logic [QUO_W-1:0] op_in;
      logic [RES_W-1:0] res_in;
      if (k == 0) begin : g_first
         assign op_cur  = quo_ff[DS];
         assign res_cur = '0;
      end else begin : g_rest
         assign op_cur  = op_ff[k-1];
         assign res_cur = res_ff[k-1];
      end
      always_comb begin
         trial = res_cur + ONE_K;
         if (RES_W'(op_cur) >= trial) begin
            op_in  = QUO_W'(RES_W'(op_cur) - trial);
            res_in = (res_cur >> 1) + ONE_K;
         end else begin
            op_in  = op_cur;
            res_in = res_cur >> 1;
         end
      end
      always_ff @(posedge clock) begin
         op_ff[k]  <= op_in;
         res_ff[k] <= res_in;
      end
   end

   // largest q with (2q-1)^2 <= quotient
   always_ff @(posedge clock) begin
      q_ff <= sts_pkg::Q_W'((res_ff[SS-1] + RES_W'(1)) >> 1);
   end

   assign out_q = q_ff;

endmodule
`default_nettype wire

@@ hdl/sts_norm.sv @@
`default_nettype none
module sts_norm (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire sts_pkg::svec_type in_vec,
   input  wire sts_pkg::tag_type  in_tag,
   output logic                   out_valid,
   output sts_pkg::tag_type       out_tag,
   output sts_pkg::vec_type       out_nrm
);

   localparam int LAT = sts_pkg::LANE_LAT;

   logic                  a_vld_ff;
   sts_pkg::svec_type     a_vec_ff;
   sts_pkg::tag_type      a_tag_ff;
   logic                  b_vld_ff;
   logic [sts_pkg::SQ_W-1:0] b_sq_ff [3];
   logic [2:0]            b_neg_ff;
   sts_pkg::tag_type      b_tag_ff;

   logic                  m_vld_ff  [LAT];
   sts_pkg::tag_type      m_tag_ff  [LAT];
   logic [2:0]            m_neg_ff  [LAT];
   logic                  m_zero_ff [LAT];

   logic                  o_vld_ff;
   sts_pkg::tag_type      o_tag_ff;
   sts_pkg::vec_type      o_nrm_ff;

   sts_pkg::scomp_type    a_c [3];
   logic [sts_pkg::SUMSQ_W-1:0] ss;
   logic [sts_pkg::Q_W-1:0]     q [3];
   sts_pkg::comp_type     n_in [3];

   assign a_c[0] = a_vec_ff.x;
   assign a_c[1] = a_vec_ff.y;
   assign a_c[2] = a_vec_ff.z;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         o_vld_ff <= m_vld_ff[LAT-1];
      end
      a_vec_ff <= in_vec;
      a_tag_ff <= in_tag;
      b_tag_ff <= a_tag_ff;
   end

   for (genvar i = 0; i < 3; i++) begin : g_sq
      logic [sts_pkg::SUM_W-1:0] m;
      assign m = a_c[i][sts_pkg::SUM_W-1] ? sts_pkg::SUM_W'(-a_c[i])
                                          : sts_pkg::SUM_W'(a_c[i]);
      always_ff @(posedge clock) begin
         b_sq_ff[i]  <= sts_pkg::SQ_W'(m * m);
         b_neg_ff[i] <= a_c[i][sts_pkg::SUM_W-1];
      end
   end

   assign ss = sts_pkg::SUMSQ_W'(b_sq_ff[0]) + sts_pkg::SUMSQ_W'(b_sq_ff[1])
             + sts_pkg::SUMSQ_W'(b_sq_ff[2]);

   for (genvar i = 0; i < 3; i++) begin : g_lane
      sts_lane u_lane (
         .clock (clock),
         .in_sq (b_sq_ff[i]),
         .in_ss (ss),
         .out_q (q[i])
      );
   end

   // side info travels alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) m_vld_ff[i] <= 1'b0;
      end else begin
         m_vld_ff[0] <= b_vld_ff;
         for (int i = 1; i < LAT; i++) m_vld_ff[i] <= m_vld_ff[i-1];
      end
      m_tag_ff[0]  <= b_tag_ff;
      m_neg_ff[0]  <= b_neg_ff;
      m_zero_ff[0] <= ss == '0;
      for (int i = 1; i < LAT; i++) begin
         m_tag_ff[i]  <= m_tag_ff[i-1];
         m_neg_ff[i]  <= m_neg_ff[i-1];
         m_zero_ff[i] <= m_zero_ff[i-1];
      end
   end

   // merge the lane magnitudes with sign and zero flag
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (m_zero_ff[LAT-1])
            n_in[i] = '0;
         else if (m_neg_ff[LAT-1][i])
            n_in[i] = -sts_pkg::comp_type'(q[i]);
         else
            n_in[i] = sts_pkg::comp_type'(q[i]);
      end
   end

   always_ff @(posedge clock) begin
      o_tag_ff   <= m_tag_ff[LAT-1];
      o_nrm_ff.x <= n_in[0];
      o_nrm_ff.y <= n_in[1];
      o_nrm_ff.z <= n_in[2];
   end

   assign out_valid = o_vld_ff;
   assign out_tag   = o_tag_ff;
   assign out_nrm   = o_nrm_ff;

endmodule
`default_nettype wire

@@ hdl/sphere_triangle_subdivider.sv @@
`default_nettype none
// Subdivides one triangle per request word (three Q1.14 vertices, ax in the lowest bits) onto
// the unit sphere, subdiv_levels times (0 to 2, larger values act as 2), and returns
// 3*4^levels vertex words depth-first, each with position and normal, tlast on the final one.
// All normalizing runs through one pipelined unit of three component lanes (31-step divider
// and 16-step square root) that takes a vector every cycle. A triangle holds the sequencer
// for a start step and the loading of its three vertices, then per level for the midpoint
// issues (3, then 12) and their round trip through the unit, then for the emission of each
// vertex as queue credit allows. A following triangle is buffered meanwhile, and results
// drain through a 64-word queue while the next triangle is already being worked.
module sphere_triangle_subdivider (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // ax, ay, az, bx, by, bz, cx, cy, cz
   input  wire logic [143:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // px, py, pz, nx, ny, nz
   output logic [95:0]       rsp_tdata,
   output logic              rsp_tlast,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int VIDX_W = sts_pkg::VIDX_W;
   localparam int FAW    = sts_pkg::FIFO_AW;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_MID  = 5'b00100,
      ST_WAIT = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]             cfg_lvl_ff;
   logic [1:0]             lvl_ff, lvl_in;
   logic                   in_vld_ff;
   sts_pkg::tri_type       in_dat_ff;
   logic [1:0]             ld_ff, ld_in;
   logic [sts_pkg::MIDX_W-1:0] mid_ff, mid_in;
   logic [sts_pkg::EMIT_W-1:0] em_ff, em_in;
   logic [3:0]             pend_ff;
   logic [FAW:0]           cred_ff;

   sts_pkg::vec_type       vmem [sts_pkg::VTX_N];
   sts_pkg::vec_type       rda_ff, rdb_ff;
   logic                   iss_vld_ff, iss_emit_ff, iss_last_ff;
   logic [VIDX_W-1:0]      iss_dest_ff;

   logic [VIDX_W-1:0]      ra, rb;
   logic                   mid_go, emit_go, emit_last, load_go;
   logic                   we;
   logic [VIDX_W-1:0]      wa;
   sts_pkg::vec_type       wd;
   sts_pkg::vec_type       ld_vec;

   sts_pkg::svec_type      n_vec;
   sts_pkg::tag_type       n_tag;
   logic                   r_vld;
   sts_pkg::tag_type       r_tag;
   sts_pkg::vec_type       r_nrm;
   logic                   r_mid, push, pop;

   sts_pkg::word_type      fifo_mem [sts_pkg::FIFO_DEPTH];
   logic [FAW-1:0]         wr_ff, rd_ff;
   logic [FAW:0]           fcnt_ff;
   logic                   rsp_vld_ff;
   sts_pkg::word_type      rsp_ff;

   logic                   csr_wr;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_ff @(posedge clock) begin
      if (reset)
         cfg_lvl_ff <= 2'd2;
      else if (csr_wr && csr_paddr[2] == sts_pkg::REG_SUBDIV)
         cfg_lvl_ff <= csr_pwdata[1:0];
   end
   assign csr_prdata = (csr_paddr[2] == sts_pkg::REG_SUBDIV) ? {30'd0, cfg_lvl_ff} : 32'd0;

   // one triangle waits here while the previous one is worked
   assign req_tready = !in_vld_ff;
   always_ff @(posedge clock) begin
      if (reset)
         in_vld_ff <= 1'b0;
      else if (req_tvalid && req_tready)
         in_vld_ff <= 1'b1;
      else if (load_go && ld_ff == 2'd2)
         in_vld_ff <= 1'b0;
      if (req_tvalid && req_tready)
         in_dat_ff <= sts_pkg::tri_type'(req_tdata);
   end

   always_comb begin
      case (ld_ff)
         2'd0:    ld_vec = in_dat_ff.a;
         2'd1:    ld_vec = in_dat_ff.b;
         default: ld_vec = in_dat_ff.c;
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      ld_in     = ld_ff;
      mid_in    = mid_ff;
      em_in     = em_ff;
      load_go   = 1'b0;
      mid_go    = 1'b0;
      emit_go   = 1'b0;
      emit_last = 1'b0;
      ra        = sts_pkg::MID_SRC_A[mid_ff];
      rb        = sts_pkg::MID_SRC_B[mid_ff];
      case (state_ff)
         ST_IDLE: begin
            if (in_vld_ff) begin
               state_in = ST_LOAD;
               ld_in    = 2'd0;
               lvl_in   = (cfg_lvl_ff > 2'(sts_pkg::MAX_LEVELS))
                          ? 2'(sts_pkg::MAX_LEVELS) : cfg_lvl_ff;
            end
         end
         ST_LOAD: begin
            load_go = 1'b1;
            ld_in   = ld_ff + 2'd1;
            if (ld_ff == 2'd2) begin
               mid_in   = '0;
               em_in    = '0;
               state_in = (lvl_ff == 2'd0) ? ST_EMIT : ST_MID;
            end
         end
         ST_MID: begin
            mid_go = 1'b1;
            mid_in = mid_ff + 1'b1;
            if (mid_ff == sts_pkg::MIDX_W'(2) || mid_ff == sts_pkg::MIDX_W'(sts_pkg::MID_N - 1))
               state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (pend_ff == 4'd0) begin
               if (mid_ff == sts_pkg::MIDX_W'(3) && lvl_ff == 2'd2)
                  state_in = ST_MID;
               else
                  state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            ra = sts_pkg::emit_vidx(lvl_ff, em_ff);
            if (cred_ff < (FAW+1)'(sts_pkg::FIFO_DEPTH)) begin
               emit_go   = 1'b1;
               emit_last = em_ff == sts_pkg::emit_total(lvl_ff) - 1'b1;
               em_in     = em_ff + 1'b1;
               if (emit_last)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
      lvl_ff <= lvl_in;
      ld_ff  <= ld_in;
      mid_ff <= mid_in;
      em_ff  <= em_in;
   end

   // vertex store
   assign r_mid = r_vld && !r_tag.emit;
   always_comb begin
      we = 1'b0;
      wa = r_tag.dest;
      wd = r_nrm;
      if (load_go) begin
         we = 1'b1;
         wa = VIDX_W'(ld_ff);
         wd = ld_vec;
      end else if (r_mid) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we)
         vmem[wa] <= wd;
      rda_ff <= vmem[ra];
      rdb_ff <= vmem[rb];
   end

   always_ff @(posedge clock) begin
      if (reset)
         iss_vld_ff <= 1'b0;
      else
         iss_vld_ff <= mid_go || emit_go;
      iss_emit_ff <= emit_go;
      iss_last_ff <= emit_last;
      iss_dest_ff <= VIDX_W'(mid_ff) + VIDX_W'(3);
   end

   always_comb begin
      if (iss_emit_ff) begin
         n_vec.x = sts_pkg::SUM_W'(rda_ff.x);
         n_vec.y = sts_pkg::SUM_W'(rda_ff.y);
         n_vec.z = sts_pkg::SUM_W'(rda_ff.z);
      end else begin
         n_vec.x = sts_pkg::scomp_type'(rda_ff.x) + sts_pkg::scomp_type'(rdb_ff.x);
         n_vec.y = sts_pkg::scomp_type'(rda_ff.y) + sts_pkg::scomp_type'(rdb_ff.y);
         n_vec.z = sts_pkg::scomp_type'(rda_ff.z) + sts_pkg::scomp_type'(rdb_ff.z);
      end
      n_tag.emit = iss_emit_ff;
      n_tag.last = iss_last_ff;
      n_tag.dest = iss_dest_ff;
      n_tag.pos  = rda_ff;
   end

   sts_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (iss_vld_ff),
      .in_vec    (n_vec),
      .in_tag    (n_tag),
      .out_valid (r_vld),
      .out_tag   (r_tag),
      .out_nrm   (r_nrm)
   );

   // outstanding midpoints and queue credits
   assign push = r_vld && r_tag.emit;
   assign pop  = fcnt_ff != '0 && (!rsp_vld_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cred_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 4'(mid_go) - 4'(r_mid);
         cred_ff <= cred_ff + (FAW+1)'(emit_go) - (FAW+1)'(pop);
      end
   end

   // result queue
   always_ff @(posedge clock) begin
      if (push)
         fifo_mem[wr_ff] <= '{last: r_tag.last, nrm: r_nrm, pos: r_tag.pos};
      if (pop)
         rsp_ff <= fifo_mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff      <= '0;
         rd_ff      <= '0;
         fcnt_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (push)
            wr_ff <= wr_ff + 1'b1;
         if (pop)
            rd_ff <= rd_ff + 1'b1;
         fcnt_ff <= fcnt_ff + (FAW+1)'(push) - (FAW+1)'(pop);
         if (pop)
            rsp_vld_ff <= 1'b1;
         else if (rsp_tready)
            rsp_vld_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_ff.nrm, rsp_ff.pos};
   assign rsp_tlast  = rsp_ff.last;

endmodule
`default_nettype wire

@@ hdl/sts_checker.sv @@
`default_nettype none
module sts_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [95:0]  rsp_tdata,
   input wire logic         rsp_tlast,
   input wire logic         csr_psel,
   input wire logic         csr_penable,
   input wire logic         csr_pwrite,
   input wire logic [2:0]   csr_paddr,
   input wire logic [31:0]  csr_pwdata,
   input wire logic [31:0]  csr_prdata,
   input wire logic         csr_pready
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response word changed");

   // nothing pending right after reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a zero position carries a zero normal
   a_zero_nrm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[47:0] == 48'd0 |-> rsp_tdata[95:48] == 48'd0)
      else $error("zero position with nonzero normal");

   // level register reads back what was written
   a_csr_rd: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[2] == 1'b0
      |=> csr_paddr[2] != 1'b0 || csr_prdata == {30'd0, $past(csr_pwdata[1:0])})
      else $error("level register readback mismatch");

endmodule

bind sphere_triangle_subdivider sts_checker u_sts_checker (.*);
`default_nettype wire

@@ dv/tb_sphere_triangle_subdivider.sv @@
`timescale 1ns / 1ps
module tb_sphere_triangle_subdivider;

   typedef struct {
      logic [15:0] px, py, pz, nx, ny, nz;
      logic        last;
   } vertex_word_type;

   typedef struct {
      int c[3];
   } ivec_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   sts_pkg::tri_type triangle_q[$];
   vertex_word_type  vertex_q[$];
   int           depth_setting;
   int           triangles_sent;
   int           vertices_checked;
   int           mismatches;
   bit           quiet_mode;
   bit           long_hold_done;
   int           send_gap;
   int           recv_gap;
   int           hold_left;

   sphere_triangle_subdivider dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // round(a * 16384 / sqrt(s)) by bisection, ties away from zero
   function automatic longint unsigned unit_scale(longint unsigned a, longint unsigned s);
      longint unsigned lo, hi, mid, d, rhs;
      lo = 0;
      hi = 16384;
      rhs = (a * a) << 30;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         d = 2 * mid - 1;
         if (d * d * s <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic ivec_type to_sphere(ivec_type v);
      ivec_type r;
      longint unsigned s, m;
      int q;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m = (v.c[i] < 0) ? longint'(-longint'(v.c[i])) : longint'(v.c[i]);
         s += m * m;
      end
      for (int i = 0; i < 3; i++) begin
         m = (v.c[i] < 0) ? longint'(-longint'(v.c[i])) : longint'(v.c[i]);
         q = (s == 0) ? 0 : int'(unit_scale(m, s));
         r.c[i] = (v.c[i] < 0) ? -q : q;
      end
      return r;
   endfunction

   function automatic void push_vertex(ivec_type p);
      vertex_word_type w;
      ivec_type n;
      n = to_sphere(p);
      w.px = p.c[0][15:0];
      w.py = p.c[1][15:0];
      w.pz = p.c[2][15:0];
      w.nx = n.c[0][15:0];
      w.ny = n.c[1][15:0];
      w.nz = n.c[2][15:0];
      w.last = 1'b0;
      vertex_q = {vertex_q, w};
   endfunction

   function automatic void add_triangle(sts_pkg::tri_type t);
      triangle_q = {triangle_q, t};
   endfunction

   function automatic ivec_type edge_midpoint(ivec_type a, ivec_type b);
      ivec_type s;
      for (int i = 0; i < 3; i++) s.c[i] = a.c[i] + b.c[i];
      return to_sphere(s);
   endfunction

   function automatic void subdivide(ivec_type v1, ivec_type v2, ivec_type v3, int lvl);
      ivec_type m12, m23, m31;
      if (lvl <= 0) begin
         push_vertex(v1);
         push_vertex(v2);
         push_vertex(v3);
         return;
      end
      m12 = edge_midpoint(v1, v2);
      m23 = edge_midpoint(v2, v3);
      m31 = edge_midpoint(v3, v1);
      subdivide(v1, m12, m31, lvl - 1);
      subdivide(v2, m23, m12, lvl - 1);
      subdivide(v3, m31, m23, lvl - 1);
      subdivide(m12, m23, m31, lvl - 1);
   endfunction

   function automatic void predict_triangle(sts_pkg::tri_type t);
      ivec_type a, b, c;
      int lvl;
      a.c[0] = int'(t.a.x); a.c[1] = int'(t.a.y); a.c[2] = int'(t.a.z);
      b.c[0] = int'(t.b.x); b.c[1] = int'(t.b.y); b.c[2] = int'(t.b.z);
      c.c[0] = int'(t.c.x); c.c[1] = int'(t.c.y); c.c[2] = int'(t.c.z);
      lvl = (depth_setting > sts_pkg::MAX_LEVELS) ? sts_pkg::MAX_LEVELS : depth_setting;
      subdivide(a, b, c, lvl);
      vertex_q[vertex_q.size() - 1].last = 1'b1;
   endfunction

   function automatic sts_pkg::comp_type random_comp();
      if ($urandom_range(9) == 0) return sts_pkg::comp_type'($urandom);
      return sts_pkg::comp_type'(int'($urandom_range(32768)) - 16384);
   endfunction

   function automatic sts_pkg::tri_type random_triangle();
      sts_pkg::tri_type t;
      t.a.x = random_comp(); t.a.y = random_comp(); t.a.z = random_comp();
      t.b.x = random_comp(); t.b.y = random_comp(); t.b.z = random_comp();
      t.c.x = random_comp(); t.c.y = random_comp(); t.c.z = random_comp();
      return t;
   endfunction

   function automatic sts_pkg::tri_type make_triangle(int ax, int ay, int az,
                                                      int bx, int by, int bz,
                                                      int cx, int cy, int cz);
      sts_pkg::tri_type t;
      t.a.x = sts_pkg::comp_type'(ax);
      t.a.y = sts_pkg::comp_type'(ay);
      t.a.z = sts_pkg::comp_type'(az);
      t.b.x = sts_pkg::comp_type'(bx);
      t.b.y = sts_pkg::comp_type'(by);
      t.b.z = sts_pkg::comp_type'(bz);
      t.c.x = sts_pkg::comp_type'(cx);
      t.c.y = sts_pkg::comp_type'(cy);
      t.c.z = sts_pkg::comp_type'(cz);
      return t;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_triangle(req_tdata);
            triangles_sent <= triangles_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (triangle_q.size() > 0) begin
               req_tdata <= triangle_q.pop_front();
               req_tvalid <= 1'b1;
               if (!quiet_mode && $urandom_range(5) == 0) send_gap <= $urandom_range(1, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      vertex_word_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (vertex_q.size() == 0) begin
               $display("%0t: unexpected vertex word, expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatches <= mismatches + 1;
            end else begin
               e = vertex_q.pop_front();
               if (rsp_tdata !== {e.nz, e.ny, e.nx, e.pz, e.py, e.px} || rsp_tlast !== e.last) begin
                  $display("%0t: vertex mismatch expected %h last %b, actual %h last %b", $time,
                           {e.nz, e.ny, e.nx, e.pz, e.py, e.px}, e.last, rsp_tdata, rsp_tlast);
                  mismatches <= mismatches + 1;
               end
            end
            vertices_checked <= vertices_checked + 1;
         end
         // one long back-pressure stretch so the input side fills up and stalls
         if (!long_hold_done && triangles_sent == 40) begin
            long_hold_done <= 1'b1;
            hold_left <= 800;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet_mode && $urandom_range(7) == 0) recv_gap <= $urandom_range(1, 13);
         end
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == 3'd0) depth_setting = value & 3;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // sampled away from the active edge so driver updates have settled
   task automatic drain();
      while (triangle_q.size() > 0 || req_tvalid || vertex_q.size() > 0) @(negedge clock);
      repeat (250) @(posedge clock);
   endtask

   initial begin
      int depths[4];
      depths = '{0, 1, 3, 2};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      depth_setting = 2;
      triangles_sent = 0;
      vertices_checked = 0;
      mismatches = 0;
      quiet_mode = 1'b0;
      long_hold_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset depth, corner values first
      add_triangle(make_triangle(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
      add_triangle(make_triangle(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
      add_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_triangle(make_triangle(16384, 0, 0, -16384, 0, 0, 0, 16384, 0));
      add_triangle(make_triangle(-32768, -32768, -32768, -32768, -32768, -32768,
                                 32767, 32767, 32767));
      add_triangle(make_triangle(32767, -1, 1, -32768, 0, -1, 1, 32767, -32768));
      add_triangle(make_triangle(16384, 16384, 16384, -16384, -16384, -16384,
                                 16384, -16384, 16384));
      add_triangle(make_triangle(1, 0, 0, 0, 1, 0, 0, 0, 1));
      add_triangle(make_triangle(-1, -1, -1, 0, 0, 0, 1, 1, 1));
      add_triangle(make_triangle(9459, 9459, 9459, -9459, 9459, -9459, 0, 0, 0));
      for (int i = 0; i < 10; i++) add_triangle(random_triangle());
      drain();

      // out-of-range register address must be ignored
      csr_write(3'd4, 32'd0);
      for (int p = 0; p < 4; p++) begin
         csr_write(3'd0, depths[p]);
         if (p == 3) quiet_mode = 1'b1;
         add_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
         add_triangle(make_triangle(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
         for (int i = 0; i < 88; i++) add_triangle(random_triangle());
         drain();
      end

      $display("covered %0d triangles and %0d vertex words over depths 2, 0, 1, 3 (saturated), 2",
               triangles_sent, vertices_checked);
      $display("included zero vectors, full-range inputs, a long output stall and random idling");
      if (mismatches == 0 && vertex_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
